FILE: design/adsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adsu_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS     = 11;
    localparam int DIFF_BITS     = PIXEL_BITS + 1;
    localparam int COND_BITS     = 16;
    localparam int QUO_BITS      = 16;
    localparam int NUM_BITS      = 48;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    // configuration register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_EDGE_K = 3'd1;
    localparam logic [2:0] REG_GAIN   = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    // conductance modes
    localparam logic [1:0] MODE_EXP      = 2'd1;
    localparam logic [1:0] MODE_RATIONAL = 2'd2;

    typedef logic [COND_BITS-1:0] cond_table_t [TABLE_ENTRIES];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_C,
        ST_RD_E,
        ST_RD_W,
        ST_SETUP,
        ST_COND,
        ST_WAIT,
        ST_MAC,
        ST_GAIN,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        CP_IDLE,
        CP_SQ,
        CP_PREP,
        CP_DIV,
        CP_POST
    } cond_phase_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  mode;
        logic [15:0] edge_k;
    } cond_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [COND_BITS-1:0] cond;
    } cond_res_t;

    function automatic cond_table_t build_cond_table();
        cond_table_t t;
        logic [63:0] a;
        a = 64'd1 << 32;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            t[i] = COND_BITS'((a + (64'd1 << 16)) >> 17);
            a = (a * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam cond_table_t COND_TABLE = build_cond_table();

endpackage
`default_nettype wire

FILE: design/adsu_cond.sv
`timescale 1ns / 1ps
`default_nettype none
module adsu_cond
    import adsu_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cond_ctl_t                   ctl,
    input  wire logic signed [DIFF_BITS-1:0] diff,
    output cond_res_t                        res
);

    cond_phase_t phase_reg, phase_next;
    logic signed [DIFF_BITS-1:0] diff_reg;
    logic [15:0]         g_reg, k_reg;
    logic [31:0]         gsq_reg, ksq_reg;
    logic                zero_reg;
    logic [NUM_BITS-1:0] rem_reg, dsh_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [3:0]          cnt_reg;
    logic                done_reg;
    logic [COND_BITS-1:0] cond_reg;

    logic [15:0] g_abs, k_eff;
    logic [32:0] den;
    logic [NUM_BITS-1:0] num, den_w;
    logic        zero_w;
    logic        fits;
    logic [31:0] qsq;

    always_comb
    begin
        g_abs = diff_reg[DIFF_BITS-1] ? 16'(-diff_reg) : 16'(diff_reg);
        k_eff = (ctl.edge_k == 16'd0) ? 16'd1 : ctl.edge_k;
        den   = {1'b0, ksq_reg};
        num   = '0;
        zero_w = 1'b0;
        unique case (ctl.mode)
            MODE_EXP:
            begin
                // index beyond the table: 16*g*g >= 256*k*k
                zero_w = ({4'b0, gsq_reg} >= ({4'b0, ksq_reg} << 4)) ? 1'b1 : 1'b0;
                num    = {12'b0, gsq_reg, 4'b0};
            end
            MODE_RATIONAL:
            begin
                den = {1'b0, ksq_reg} + {1'b0, gsq_reg};
                num = ({16'b0, ksq_reg} << 15) + {16'b0, den[32:1]};
            end
            default:
            begin
                zero_w = (g_reg > k_reg);
                num    = ({16'b0, ksq_reg - gsq_reg} << 15) + {17'b0, ksq_reg[31:1]};
            end
        endcase
        den_w = {den, 15'b0};
        fits  = (rem_reg >= dsh_reg);
        qsq   = 32'(quo_reg) * 32'(quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= CP_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            CP_IDLE: if (ctl.start) phase_next = CP_SQ;
            CP_SQ:   phase_next = CP_PREP;
            CP_PREP: phase_next = CP_DIV;
            CP_DIV:  if (cnt_reg == 4'd15) phase_next = CP_POST;
            CP_POST: phase_next = CP_IDLE;
            default: phase_next = CP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (phase_reg == CP_POST);
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            CP_IDLE: diff_reg <= diff;
            CP_SQ:
            begin
                g_reg   <= g_abs;
                k_reg   <= k_eff;
                gsq_reg <= 32'(g_abs) * 32'(g_abs);
                ksq_reg <= 32'(k_eff) * 32'(k_eff);
            end
            CP_PREP:
            begin
                zero_reg <= zero_w;
                rem_reg  <= num;
                dsh_reg  <= den_w;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            CP_DIV:
            begin
                if (fits)
                    rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + 4'd1;
            end
            CP_POST:
            begin
                if (zero_reg)
                    cond_reg <= '0;
                else if (ctl.mode == MODE_EXP)
                    cond_reg <= COND_TABLE[quo_reg[7:0]];
                else if (ctl.mode == MODE_RATIONAL)
                    cond_reg <= quo_reg;
                else
                    cond_reg <= COND_BITS'((qsq + 32'd32768) >> 16);
            end
            default: ;
        endcase
    end

    assign res.done = done_reg;
    assign res.cond = cond_reg;

endmodule
`default_nettype wire

FILE: design/anisotropic_diffusion_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// one perona-malik diffusion pass over a raster-order pixel stream
// s_axis: tdata carries the old pixel, tuser the kind (0 pixel, 1 flush)
// m_axis: tdata carries the updated pixel, tlast marks the frame's last pixel
// cfg: plain write port, index 0 mode, 1 edge_k, 2 step_gain, 3 width, 4 height;
//   a width or height write restarts the frame counters
// results lag the input by one row; after the last pixel of a frame, one
//   flush request per pending pixel drains the final row
// a pixel of row 0, or a flush with nothing pending, is taken without starting the sequencer
// any other request runs the sequencer: four neighbour directions pass
//   one at a time through the shared conductance unit, whose restoring
//   divider yields one quotient bit a cycle for a 16-bit quotient, plus line-store
//   reads, multiply-accumulate, gain and rounding steps
// s_axis_tready is high only while the sequencer is idle
// a finished result sits in the output register; the next request is taken
//   while it waits, and the sequencer holds its own result while that register is full and m_axis_tready is low
// reset clears counters, configuration to defaults and the output valid flag;
//   line stores keep no reset and are read only after being written
module anisotropic_diffusion_step_unit
    import adsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] pixel_in
    input  wire logic        s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] pixel_out
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    // configuration
    logic [1:0]           mode_reg;
    logic [15:0]          edge_k_reg, gain_reg;
    logic [SIZE_BITS-1:0] fw_reg, fh_reg;

    // stream position
    logic [COL_BITS-1:0]  col_cnt_reg;
    logic [ROW_BITS-1:0]  row_cnt_reg;
    logic [SIZE_BITS-1:0] pend_reg;

    // current request
    logic                 flush_reg, has_n_reg, has_e_reg, has_w_reg, end_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic signed [PIXEL_BITS-1:0] pix_reg, cen_reg, nor_reg, east_reg;
    logic signed [PIXEL_BITS-1:0] nb_reg [4];
    logic signed [PIXEL_BITS-1:0] west_hold_reg;
    logic [1:0]           dir_reg;
    logic [COND_BITS-1:0] cond_reg;
    logic signed [34:0]   acc_reg;
    logic signed [51:0]   prod_reg;
    logic signed [PIXEL_BITS-1:0] res_reg;

    // output register
    logic                 out_valid_reg;
    logic [15:0]          out_pix_reg;
    logic                 out_end_reg;

    // line stores
    logic [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] up_mem  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mid_q, up_q;
    logic [COL_BITS-1:0]   mid_raddr;

    logic [SIZE_BITS-1:0] n_eff, m_eff, flush_col;
    logic                 accept, acc_pix, row0_pix, start_pix, start_flush, out_load;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [33:0]   term;
    logic signed [52:0]   t_round;
    logic signed [22:0]   r_sum;
    cond_ctl_t            cond_ctl;
    cond_res_t            cond_res;

    always_comb
    begin
        n_eff = (fw_reg == '0) ? SIZE_BITS'(1) :
                (fw_reg > SIZE_BITS'(MAX_WIDTH)) ? SIZE_BITS'(MAX_WIDTH) : fw_reg;
        m_eff = (fh_reg == '0) ? SIZE_BITS'(1) :
                (fh_reg > SIZE_BITS'(MAX_HEIGHT)) ? SIZE_BITS'(MAX_HEIGHT) : fh_reg;
        flush_col   = n_eff - pend_reg;
        accept      = s_axis_tvalid && s_axis_tready;
        acc_pix     = accept && !s_axis_tuser;
        row0_pix    = acc_pix && (row_cnt_reg == '0);
        start_pix   = acc_pix && (row_cnt_reg != '0);
        start_flush = accept && s_axis_tuser && (pend_reg != '0);
        out_load    = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
        diff        = DIFF_BITS'(nb_reg[dir_reg]) - DIFF_BITS'(cen_reg);
        term        = 34'($signed({1'b0, cond_reg})) * 34'(diff);
        t_round     = 53'(prod_reg) + (53'sd1 <<< 30);
        r_sum       = 23'(cen_reg) + 23'($signed(t_round[52:31]));
        unique case (state_reg)
            ST_RD_E: mid_raddr = col_reg + COL_BITS'(1);
            ST_RD_W: mid_raddr = col_reg - COL_BITS'(1);
            default: mid_raddr = col_reg;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start_pix || start_flush) state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_RD_E;
            ST_RD_E:  state_next = ST_RD_W;
            ST_RD_W:  state_next = ST_SETUP;
            ST_SETUP: state_next = ST_COND;
            ST_COND:  state_next = ST_WAIT;
            ST_WAIT:  if (cond_res.done) state_next = ST_MAC;
            ST_MAC:   state_next = (dir_reg == 2'd3) ? ST_GAIN : ST_COND;
            ST_GAIN:  state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // configuration and stream counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 2'd0;
            edge_k_reg  <= 16'd64;
            gain_reg    <= 16'd16384;
            fw_reg      <= SIZE_BITS'(1024);
            fh_reg      <= SIZE_BITS'(1024);
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pend_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_EDGE_K: edge_k_reg <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_WIDTH:
                begin
                    fw_reg      <= cfg_data[SIZE_BITS-1:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                    pend_reg    <= '0;
                end
                REG_HEIGHT:
                begin
                    fh_reg      <= cfg_data[SIZE_BITS-1:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                    pend_reg    <= '0;
                end
                default: ;
            endcase
        end
        else if (acc_pix)
        begin
            pend_reg <= '0;
            if (SIZE_BITS'(col_cnt_reg) + SIZE_BITS'(1) >= n_eff)
            begin
                col_cnt_reg <= '0;
                if (SIZE_BITS'(row_cnt_reg) + SIZE_BITS'(1) >= m_eff)
                begin
                    row_cnt_reg <= '0;
                    pend_reg    <= n_eff;
                end
                else
                    row_cnt_reg <= row_cnt_reg + ROW_BITS'(1);
            end
            else
                col_cnt_reg <= col_cnt_reg + COL_BITS'(1);
        end
        else if (start_flush)
            pend_reg <= pend_reg - SIZE_BITS'(1);
    end

    // request latch and arithmetic steps
    always_ff @(posedge clk)
    begin
        if (start_pix)
        begin
            flush_reg <= 1'b0;
            col_reg   <= col_cnt_reg;
            pix_reg   <= s_axis_tdata;
            has_n_reg <= (row_cnt_reg >= ROW_BITS'(2));
            has_w_reg <= (col_cnt_reg != '0);
            has_e_reg <= (SIZE_BITS'(col_cnt_reg) + SIZE_BITS'(1) < n_eff);
            end_reg   <= 1'b0;
        end
        else if (start_flush)
        begin
            flush_reg <= 1'b1;
            col_reg   <= flush_col[COL_BITS-1:0];
            has_n_reg <= (m_eff >= SIZE_BITS'(2));
            has_w_reg <= (flush_col != '0);
            has_e_reg <= (flush_col + SIZE_BITS'(1) < n_eff);
            end_reg   <= (pend_reg == SIZE_BITS'(1));
        end
        unique case (state_reg)
            ST_RD_E:
            begin
                cen_reg <= mid_q;
                nor_reg <= up_q;
            end
            ST_RD_W: east_reg <= mid_q;
            ST_SETUP:
            begin
                nb_reg[0] <= has_n_reg ? nor_reg : cen_reg;
                nb_reg[1] <= flush_reg ? cen_reg : pix_reg;
                nb_reg[2] <= has_e_reg ? east_reg : cen_reg;
                nb_reg[3] <= !has_w_reg ? cen_reg :
                             flush_reg ? $signed(mid_q) : west_hold_reg;
                if (!flush_reg)
                    west_hold_reg <= cen_reg;
                dir_reg <= 2'd0;
                acc_reg <= '0;
            end
            ST_WAIT: if (cond_res.done) cond_reg <= cond_res.cond;
            ST_MAC:
            begin
                acc_reg <= acc_reg + 35'(term);
                dir_reg <= dir_reg + 2'd1;
            end
            ST_GAIN:  prod_reg <= 52'(acc_reg) * 52'($signed({1'b0, gain_reg}));
            ST_ROUND:
            begin
                if (r_sum > 23'sd32767)
                    res_reg <= 16'sh7FFF;
                else if (r_sum < -23'sd32768)
                    res_reg <= 16'sh8000;
                else
                    res_reg <= r_sum[15:0];
            end
            default: ;
        endcase
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (row0_pix)
            mid_mem[col_cnt_reg] <= s_axis_tdata;
        else if (state_reg == ST_SETUP && !flush_reg)
            mid_mem[col_reg] <= pix_reg;
        if (state_reg == ST_SETUP && !flush_reg)
            up_mem[col_reg] <= cen_reg;
        mid_q <= mid_mem[mid_raddr];
        up_q  <= up_mem[col_reg];
    end

    assign cond_ctl.start  = (state_reg == ST_COND);
    assign cond_ctl.mode   = mode_reg;
    assign cond_ctl.edge_k = edge_k_reg;

    adsu_cond u_cond (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cond_ctl),
        .diff  (diff),
        .res   (cond_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pix_reg <= res_reg;
            out_end_reg <= end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_end_reg;

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= SIZE_BITS'(MAX_WIDTH))
        else $error("pending count beyond row length");
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cond_res.done |-> state_reg == ST_WAIT)
        else $error("conductance result outside wait state");
    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (start_flush && !cfg_we && pend_reg == SIZE_BITS'(1)) |=> pend_reg == '0)
        else $error("last flush left pixels pending");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_anisotropic_diffusion_step_unit.sv
`timescale 1ns / 1ps
module tb_anisotropic_diffusion_step_unit;
    import adsu_pkg::*;

    // conductance modes not named in the package
    localparam logic [1:0] MODE_TUKEY = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int  ITEM_TARGET  = 1450;
    localparam int  SETTLE_WAIT  = 200;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct {
        bit          kind;     // 0 pixel, 1 flush
        logic [15:0] pix;
    } request_t;

    typedef struct {
        logic [15:0] pix;
        bit          last;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    anisotropic_diffusion_step_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    request_t      request_queue[$];   // requests not yet offered
    pixel_result_t pixel_expected[$];  // predicted results in order
    int            mismatch_count;
    int            items_sent;
    longint        cycle_count;

    // ---------------------------------------------------------------
    // diffusion predictor: own copy of configuration and row stores
    // ---------------------------------------------------------------
    logic [1:0]   cur_mode;
    logic [15:0]  cur_k;
    logic [15:0]  cur_gain;
    logic [10:0]  cur_width;
    logic [10:0]  cur_height;
    longint       row_above [MAX_WIDTH];
    longint       row_mid   [MAX_WIDTH];
    int unsigned  col_pos, row_pos, flush_left;
    longint       west_pixel;
    logic [15:0]  exp_table [TABLE_ENTRIES];

    function automatic int unsigned used_width();
        if (cur_width < 1) return 1;
        if (cur_width > MAX_WIDTH) return MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned used_height();
        if (cur_height < 1) return 1;
        if (cur_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cur_height;
    endfunction

    // conductance in q1.15 for one neighbour difference
    function automatic longint unsigned edge_stop(longint diff);
        longint unsigned k, ksq, g, gsq, idx, den, q;
        k   = (cur_k == 0) ? 1 : cur_k;
        ksq = k * k;
        g   = (diff < 0) ? -diff : diff;
        if (g > 64'hFFFFFF) g = 64'hFFFFFF;
        gsq = g * g;
        if (cur_mode == MODE_EXP)
        begin
            idx = (gsq * 16) / ksq;
            return (idx >= TABLE_ENTRIES) ? 0 : exp_table[idx];
        end
        if (cur_mode == MODE_RATIONAL)
        begin
            den = ksq + gsq;
            return ((ksq << 15) + den / 2) / den;
        end
        if (g > k) return 0;
        q = (((ksq - gsq) << 15) + ksq / 2) / ksq;
        return (q * q + 32768) >> 16;
    endfunction

    function automatic logic [15:0] diffused_pixel(longint c, longint n, longint s,
                                                   longint e, longint w);
        longint d [4];
        longint acc, t, r;
        acc = 0;
        d[0] = n - c; d[1] = s - c; d[2] = e - c; d[3] = w - c;
        for (int i = 0; i < 4; i++)
            acc += longint'(edge_stop(d[i])) * d[i];
        if (acc > (64'sd1 <<< 46)) acc = 64'sd1 <<< 46;
        if (acc < -(64'sd1 <<< 46)) acc = -(64'sd1 <<< 46);
        t = acc * longint'(cur_gain) + (64'sd1 <<< 30);
        r = c + (t >>> 31);   // arithmetic shift floors
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic void restart_stream();
        col_pos = 0; row_pos = 0; flush_left = 0; west_pixel = 0;
    endfunction

    function automatic void predict_cfg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_MODE:   cur_mode = val[1:0];
            REG_EDGE_K: cur_k = val;
            REG_GAIN:   cur_gain = val;
            REG_WIDTH:  begin cur_width = val[10:0]; restart_stream(); end
            REG_HEIGHT: begin cur_height = val[10:0]; restart_stream(); end
            default: ;
        endcase
    endfunction

    function automatic void predict_request(bit kind, logic [15:0] raw);
        int unsigned   n, m, col;
        longint        p, cen, no, ea, we;
        pixel_result_t res;
        n = used_width();
        m = used_height();
        if (kind)
        begin
            // flush: drain one pixel of the last row, south replicates centre
            if (flush_left == 0) return;
            col = (n >= flush_left) ? n - flush_left : 0;
            if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
            cen = row_mid[col];
            no  = (m >= 2) ? row_above[col] : cen;
            we  = (col > 0) ? row_mid[col-1] : cen;
            ea  = (col + 1 < n) ? row_mid[col+1] : cen;
            flush_left--;
            res.pix  = diffused_pixel(cen, no, cen, ea, we);
            res.last = (flush_left == 0);
            pixel_expected.push_back(res);
            return;
        end
        p = longint'($signed(raw));
        flush_left = 0;   // a pixel drops whatever was still pending
        col = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        if (row_pos == 0)
            row_mid[col] = p;
        else
        begin
            cen = row_mid[col];
            no  = (row_pos >= 2) ? row_above[col] : cen;
            we  = (col > 0) ? west_pixel : cen;
            ea  = (col + 1 < n) ? row_mid[col+1] : cen;
            res.pix  = diffused_pixel(cen, no, p, ea, we);
            res.last = 1'b0;
            pixel_expected.push_back(res);
            west_pixel     = cen;
            row_above[col] = cen;
            row_mid[col]   = p;
        end
        if (col_pos + 1 >= n)
        begin
            col_pos = 0;
            if (row_pos + 1 >= m)
            begin
                row_pos    = 0;
                flush_left = n;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts of requests with random gaps
    // ---------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        request_t req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            burst_left    = 4;
            gap_left      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    req = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= req.kind;
                    s_axis_tdata  <= req.pix;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // some bursts run straight on with no gap at all
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: receiver stalls with a changing duty, checks each result
    // ---------------------------------------------------------------
    int stall_pct;
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_pct   = 0;
            stall_phase = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result pixel %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = pixel_expected.pop_front();
                    if (m_axis_tdata !== want.pix || m_axis_tlast !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: pixel exp %h got %h, last exp %b got %b",
                                     want.pix, m_axis_tdata, want.last, m_axis_tlast);
                    end
                end
            end
            stall_phase++;
            if (stall_phase >= 150)
            begin
                stall_phase = 0;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 85;
                endcase
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        predict_cfg(idx, val);
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold off until every request is taken and every result is back
    task automatic wait_idle();
        while (request_queue.size() > 0 || s_axis_tvalid || pixel_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic send(bit kind, logic [15:0] pix);
        request_t r;
        r.kind = kind;
        r.pix  = pix;
        request_queue.push_back(r);
        items_sent++;
    endtask

    // style 0 full range, 1 smooth around a base, 2 extremes
    function automatic logic [15:0] pick_pixel(int style, int base);
        int v, spread;
        case (style)
            0: return 16'($urandom);
            1:
            begin
                spread = (cur_k < 16) ? 16 : 2 * cur_k;
                if (spread > 20000) spread = 20000;
                v = base + $urandom_range(0, 2 * spread) - spread;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return 16'(v);
            end
            default:
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
        endcase
    endfunction

    task automatic random_config();
        int sel;
        write_reg(REG_MODE, 16'($urandom_range(0, 3)));
        sel = $urandom_range(0, 9);
        write_reg(REG_EDGE_K, (sel == 0) ? 16'd1 : (sel == 1) ? 16'hFFFF :
                              (sel == 2) ? 16'd0 : 16'($urandom_range(2, 3000)));
        sel = $urandom_range(0, 9);
        write_reg(REG_GAIN, (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                            16'($urandom));
        write_reg(REG_WIDTH,  16'($urandom_range(1, 8)));
        write_reg(REG_HEIGHT, 16'($urandom_range(1, 5)));
        end_writes();
    endtask

    // a few frames, mostly well formed, with broken drains and stray flushes
    task automatic random_phase();
        int frames, n, m, style, base, drain;
        n = used_width();
        m = used_height();
        frames = $urandom_range(1, 4);
        for (int f = 0; f < frames; f++)
        begin
            style = $urandom_range(0, 5) < 4 ? 1 : $urandom_range(0, 2);
            base  = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < n * m; i++)
            begin
                if ($urandom_range(0, 29) == 0) send(1'b1, 16'($urandom));
                send(1'b0, pick_pixel(style, base));
            end
            case ($urandom_range(0, 5))
                0: drain = $urandom_range(0, n);      // cut short, next pixel drops the rest
                1: drain = n + $urandom_range(1, 3);  // extra flushes find nothing
                default: drain = n;
            endcase
            for (int i = 0; i < drain; i++) send(1'b1, 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatch_count = 0;
        items_sent    = 0;
        cycle_count   = 0;
        cur_mode = MODE_TUKEY; cur_k = 16'd64; cur_gain = 16'd16384;
        cur_width = 11'd1024; cur_height = 11'd1024;
        restart_stream();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_above[i] = 0;
            row_mid[i]   = 0;
        end
        begin
            longint unsigned a;
            a = 64'd1 << 32;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                exp_table[i] = 16'((a + (64'd1 << 16)) >> 17);
                a = (a * 64'd4034748382 + (64'd1 << 31)) >> 32;
            end
        end
        repeat (4) @(posedge clk);
        rst_n = 1'b1;

        // directed: 3x3 exponential, extreme pixels, extra flush, pixel during drain
        write_reg(REG_MODE, MODE_EXP);
        write_reg(REG_EDGE_K, 16'd64);
        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd3);
        end_writes();
        send(1'b1, 16'h0000);                  // flush with nothing pending
        send(1'b0, 16'h7FFF); send(1'b0, 16'h8000); send(1'b0, 16'h0000);
        send(1'b0, 16'hFFFF); send(1'b0, 16'h0001); send(1'b0, 16'h7FFF);
        send(1'b0, 16'h5555); send(1'b0, 16'hAAAA); send(1'b0, 16'h8000);
        send(1'b1, 16'h0000); send(1'b1, 16'h0000); send(1'b1, 16'h0000);
        send(1'b1, 16'hFFFF);                  // drained already
        for (int i = 0; i < 9; i++) send(1'b0, 16'(i * 40 - 100));
        send(1'b1, 16'h0000);                  // one flush, then a pixel drops the rest
        send(1'b0, 16'h0010);
        wait_idle();

        // rational mode with the widest row, partly into the second row
        write_reg(REG_MODE, MODE_RATIONAL);
        write_reg(REG_EDGE_K, 16'hFFFF);
        write_reg(REG_GAIN, 16'd0);
        write_reg(REG_WIDTH, 16'd1024);
        write_reg(REG_HEIGHT, 16'd2);
        end_writes();
        for (int i = 0; i < 1024 + 30; i++) send(1'b0, 16'($urandom));
        wait_idle();

        // tallest column, spare mode, zero threshold
        write_reg(REG_MODE, MODE_SPARE);
        write_reg(REG_EDGE_K, 16'd0);
        write_reg(REG_GAIN, 16'd32768);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd1024);
        end_writes();
        for (int i = 0; i < 20; i++) send(1'b0, 16'($urandom_range(0, 3)));
        wait_idle();

        // zero sizes act as one: every pixel ends a frame
        write_reg(REG_MODE, MODE_TUKEY);
        write_reg(REG_EDGE_K, 16'd1);
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        end_writes();
        for (int i = 0; i < 6; i++)
        begin
            send(1'b0, 16'($urandom));
            send(1'b1, 16'h0000);
        end
        wait_idle();

        while (items_sent < ITEM_TARGET)
        begin
            random_config();
            random_phase();
            wait_idle();
        end

        if (mismatch_count == 0 && pixel_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
